[rtl/aabb_pkg.sv]
// Shared types and constants for the box overlap and push-out block.
`default_nettype none
package aabb_pkg;

    // Default signed width of a centre coordinate
    localparam int COORD_BITS_DEF = 16;
    // Half extent and velocity widths are fixed by the interface
    localparam int HALF_BITS = 14;
    localparam int VEL_BITS  = 16;
    // Width of a summed half extent
    localparam int SUM_BITS  = HALF_BITS + 1;
    // Width of a penetration times velocity product
    localparam int PROD_BITS = SUM_BITS + VEL_BITS;

    // Side code of a result
    typedef enum logic [1:0] {
        HIT_NONE  = 2'd0,
        HIT_PLUS  = 2'd1,
        HIT_MINUS = 2'd2
    } hit_code_t;

    // Control flags passed from the overlap stage to the push-out stage
    typedef struct packed {
        logic valid;   // transaction present in this stage
        logic hit;     // boxes overlap and a second body exists
        logic stat;    // self is static, other body moves
        logic pos_x;   // mover goes to the positive side on X
        logic pos_y;   // mover goes to the positive side on Y
    } aabb_ctrl_t;

endpackage
`default_nettype wire

[rtl/aabb_prep.sv]
// Overlap stage: distances, overlap test, penetrations and mover selection.
`default_nettype none
module aabb_prep #(
    parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic                                other_valid,
    input  wire logic                                self_static,
    input  wire logic signed [COORD_BITS-1:0]        self_x,
    input  wire logic signed [COORD_BITS-1:0]        self_y,
    input  wire logic [aabb_pkg::HALF_BITS-1:0]      self_half_w,
    input  wire logic [aabb_pkg::HALF_BITS-1:0]      self_half_h,
    input  wire logic signed [COORD_BITS-1:0]        other_x,
    input  wire logic signed [COORD_BITS-1:0]        other_y,
    input  wire logic [aabb_pkg::HALF_BITS-1:0]      other_half_w,
    input  wire logic [aabb_pkg::HALF_BITS-1:0]      other_half_h,
    input  wire logic signed [aabb_pkg::VEL_BITS-1:0] mover_vx,
    input  wire logic signed [aabb_pkg::VEL_BITS-1:0] mover_vy,
    output aabb_pkg::aabb_ctrl_t                     ctrl,
    output logic [aabb_pkg::SUM_BITS-1:0]            pen_x,
    output logic [aabb_pkg::SUM_BITS-1:0]            pen_y,
    output logic [aabb_pkg::VEL_BITS-1:0]            vel_x,
    output logic [aabb_pkg::VEL_BITS-1:0]            vel_y,
    output logic [aabb_pkg::SUM_BITS-1:0]            ext_x,
    output logic [aabb_pkg::SUM_BITS-1:0]            ext_y,
    output logic signed [COORD_BITS-1:0]             base_x,
    output logic signed [COORD_BITS-1:0]             base_y,
    output logic signed [COORD_BITS-1:0]             keep_x,
    output logic signed [COORD_BITS-1:0]             keep_y
);
    import aabb_pkg::*;

    // Distance width and compare width
    localparam int GW = COORD_BITS + 1;
    localparam int CW = (GW > SUM_BITS) ? GW : SUM_BITS;

    logic signed [GW-1:0]   dx, dy;
    logic [GW-1:0]          gx, gy;
    logic [SUM_BITS-1:0]    cx, cy;
    logic [CW-1:0]          gx_ext, gy_ext, cx_ext, cy_ext, px_full, py_full;
    logic                   overlap;

    aabb_ctrl_t             ctrl_reg, ctrl_next;
    logic [SUM_BITS-1:0]    pen_x_reg, pen_y_reg, ext_x_reg, ext_y_reg;
    logic [VEL_BITS-1:0]    vel_x_reg, vel_y_reg, vel_x_next, vel_y_next;
    logic signed [COORD_BITS-1:0] base_x_reg, base_y_reg, keep_x_reg, keep_y_reg;

    // Center distances and summed half extents
    always_comb
    begin
        dx = GW'(other_x) - GW'(self_x);
        dy = GW'(other_y) - GW'(self_y);
        gx = dx[GW-1] ? GW'(-dx) : GW'(dx);
        gy = dy[GW-1] ? GW'(-dy) : GW'(dy);
        cx = SUM_BITS'(other_half_w) + SUM_BITS'(self_half_w);
        cy = SUM_BITS'(other_half_h) + SUM_BITS'(self_half_h);
        gx_ext = CW'(gx);
        gy_ext = CW'(gy);
        cx_ext = CW'(cx);
        cy_ext = CW'(cy);
        overlap = (gx_ext < cx_ext) && (gy_ext < cy_ext);
        px_full = cx_ext - gx_ext;
        py_full = cy_ext - gy_ext;
    end

    // Velocity magnitudes (most negative value maps to 2^15 unsigned)
    always_comb
    begin
        vel_x_next = mover_vx[VEL_BITS-1] ? (~mover_vx + 1'b1) : mover_vx;
        vel_y_next = mover_vy[VEL_BITS-1] ? (~mover_vy + 1'b1) : mover_vy;
    end

    // Flags; equal centers send the mover to the negative side
    always_comb
    begin
        ctrl_next.valid = in_valid;
        ctrl_next.hit   = in_valid && other_valid && overlap;
        ctrl_next.stat  = self_static;
        ctrl_next.pos_x = self_static ? (other_x > self_x) : (other_x < self_x);
        ctrl_next.pos_y = self_static ? (other_y > self_y) : (other_y < self_y);
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        pen_x_reg  <= px_full[SUM_BITS-1:0];
        pen_y_reg  <= py_full[SUM_BITS-1:0];
        ext_x_reg  <= cx;
        ext_y_reg  <= cy;
        vel_x_reg  <= vel_x_next;
        vel_y_reg  <= vel_y_next;
        base_x_reg <= self_static ? self_x : other_x;
        base_y_reg <= self_static ? self_y : other_y;
        keep_x_reg <= self_static ? other_x : self_x;
        keep_y_reg <= self_static ? other_y : self_y;
    end

    assign ctrl   = ctrl_reg;
    assign pen_x  = pen_x_reg;
    assign pen_y  = pen_y_reg;
    assign vel_x  = vel_x_reg;
    assign vel_y  = vel_y_reg;
    assign ext_x  = ext_x_reg;
    assign ext_y  = ext_y_reg;
    assign base_x = base_x_reg;
    assign base_y = base_y_reg;
    assign keep_x = keep_x_reg;
    assign keep_y = keep_y_reg;

endmodule
`default_nettype wire

[rtl/aabb_resolve.sv]
// Push-out stage: axis choice by cross products, new position, saturation.
`default_nettype none
module aabb_resolve #(
    parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire aabb_pkg::aabb_ctrl_t             ctrl,
    input  wire logic [aabb_pkg::SUM_BITS-1:0]    pen_x,
    input  wire logic [aabb_pkg::SUM_BITS-1:0]    pen_y,
    input  wire logic [aabb_pkg::VEL_BITS-1:0]    vel_x,
    input  wire logic [aabb_pkg::VEL_BITS-1:0]    vel_y,
    input  wire logic [aabb_pkg::SUM_BITS-1:0]    ext_x,
    input  wire logic [aabb_pkg::SUM_BITS-1:0]    ext_y,
    input  wire logic signed [COORD_BITS-1:0]     base_x,
    input  wire logic signed [COORD_BITS-1:0]     base_y,
    input  wire logic signed [COORD_BITS-1:0]     keep_x,
    input  wire logic signed [COORD_BITS-1:0]     keep_y,
    output logic                                  done,
    output logic [1:0]                            hit_code,
    output logic                                  moved_other,
    output logic signed [COORD_BITS-1:0]          new_x,
    output logic signed [COORD_BITS-1:0]          new_y
);
    import aabb_pkg::*;

    // Push sum width: coordinate plus offset plus sign headroom
    localparam int W = ((COORD_BITS > SUM_BITS) ? COORD_BITS : SUM_BITS) + 2;
    localparam logic signed [W-1:0] MAXV = {{(W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {{(W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    logic [PROD_BITS-1:0]       lhs, rhs;
    logic                       use_x;
    logic signed [W-1:0]        off_x, off_y, sum_x, sum_y;
    logic signed [COORD_BITS-1:0] push_x, push_y;

    logic                       done_reg;
    hit_code_t                  code_reg, code_next;
    logic                       moved_reg, moved_next;
    logic signed [COORD_BITS-1:0] new_x_reg, new_x_next, new_y_reg, new_y_next;

    // Clamp a wide signed sum to the coordinate range
    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [W-1:0] v);
        logic signed [W-1:0] c;
        c = v;
        if (v > MAXV)
            c = MAXV;
        else if (v < MINV)
            c = MINV;
        return c[COORD_BITS-1:0];
    endfunction

    // X wins only when pen_x/|vx| is strictly smaller
    always_comb
    begin
        lhs   = PROD_BITS'(pen_x) * PROD_BITS'(vel_y);
        rhs   = PROD_BITS'(pen_y) * PROD_BITS'(vel_x);
        use_x = lhs < rhs;
    end

    // Place mover one unit beyond the summed half extent
    always_comb
    begin
        off_x  = $signed(W'(ext_x) + W'(1));
        off_y  = $signed(W'(ext_y) + W'(1));
        sum_x  = ctrl.pos_x ? (W'(base_x) + off_x) : (W'(base_x) - off_x);
        sum_y  = ctrl.pos_y ? (W'(base_y) + off_y) : (W'(base_y) - off_y);
        push_x = sat(sum_x);
        push_y = sat(sum_y);
    end

    // Result selection; no collision gives all zero fields
    always_comb
    begin
        code_next  = HIT_NONE;
        moved_next = 1'b0;
        new_x_next = '0;
        new_y_next = '0;
        if (ctrl.hit)
        begin
            moved_next = ctrl.stat;
            if (use_x)
            begin
                code_next  = ctrl.stat ? HIT_PLUS : HIT_MINUS;
                new_x_next = push_x;
                new_y_next = keep_y;
            end
            else
            begin
                code_next  = ctrl.stat ? HIT_MINUS : HIT_PLUS;
                new_x_next = keep_x;
                new_y_next = push_y;
            end
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        moved_reg <= moved_next;
        new_x_reg <= new_x_next;
        new_y_reg <= new_y_next;
    end

    assign done        = done_reg;
    assign hit_code    = code_reg;
    assign moved_other = moved_reg;
    assign new_x       = new_x_reg;
    assign new_y       = new_y_reg;

endmodule
`default_nettype wire

[rtl/aabb_collision_resolve.sv]
// Top level: box overlap test with push-out of the moving body.
// done rises once an accepted start has passed the input, overlap and result registers.
// Throughput: one transaction per cycle; busy is never asserted; the receiver cannot stall.
// Path: input register, overlap stage, cross-product compare and push stage.
// Reset clears the stage valid flags and the done strobe; payload is not reset.
`default_nettype none
module aabb_collision_resolve #(
    parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    output logic                                     done,
    input  wire logic                                other_valid,
    input  wire logic                                self_static,
    input  wire logic signed [COORD_BITS-1:0]        self_x,
    input  wire logic signed [COORD_BITS-1:0]        self_y,
    input  wire logic [aabb_pkg::HALF_BITS-1:0]      self_half_w,
    input  wire logic [aabb_pkg::HALF_BITS-1:0]      self_half_h,
    input  wire logic signed [COORD_BITS-1:0]        other_x,
    input  wire logic signed [COORD_BITS-1:0]        other_y,
    input  wire logic [aabb_pkg::HALF_BITS-1:0]      other_half_w,
    input  wire logic [aabb_pkg::HALF_BITS-1:0]      other_half_h,
    input  wire logic signed [aabb_pkg::VEL_BITS-1:0] mover_vx,
    input  wire logic signed [aabb_pkg::VEL_BITS-1:0] mover_vy,
    output logic [1:0]                               hit_code,
    output logic                                     moved_other,
    output logic signed [COORD_BITS-1:0]             new_x,
    output logic signed [COORD_BITS-1:0]             new_y
);
    import aabb_pkg::*;

    logic                          in_valid_reg;
    logic                          other_valid_reg, self_static_reg;
    logic signed [COORD_BITS-1:0]  self_x_reg, self_y_reg, other_x_reg, other_y_reg;
    logic [HALF_BITS-1:0]          self_half_w_reg, self_half_h_reg;
    logic [HALF_BITS-1:0]          other_half_w_reg, other_half_h_reg;
    logic signed [VEL_BITS-1:0]    mover_vx_reg, mover_vy_reg;
    logic                          accept;

    aabb_ctrl_t                    ctrl;
    logic [SUM_BITS-1:0]           pen_x, pen_y, ext_x, ext_y;
    logic [VEL_BITS-1:0]           vel_x, vel_y;
    logic signed [COORD_BITS-1:0]  base_x, base_y, keep_x, keep_y;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Input valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            other_valid_reg  <= other_valid;
            self_static_reg  <= self_static;
            self_x_reg       <= self_x;
            self_y_reg       <= self_y;
            self_half_w_reg  <= self_half_w;
            self_half_h_reg  <= self_half_h;
            other_x_reg      <= other_x;
            other_y_reg      <= other_y;
            other_half_w_reg <= other_half_w;
            other_half_h_reg <= other_half_h;
            mover_vx_reg     <= mover_vx;
            mover_vy_reg     <= mover_vy;
        end
    end

    aabb_prep #(
        .COORD_BITS(COORD_BITS)
    ) u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid_reg),
        .other_valid (other_valid_reg),
        .self_static (self_static_reg),
        .self_x      (self_x_reg),
        .self_y      (self_y_reg),
        .self_half_w (self_half_w_reg),
        .self_half_h (self_half_h_reg),
        .other_x     (other_x_reg),
        .other_y     (other_y_reg),
        .other_half_w(other_half_w_reg),
        .other_half_h(other_half_h_reg),
        .mover_vx    (mover_vx_reg),
        .mover_vy    (mover_vy_reg),
        .ctrl        (ctrl),
        .pen_x       (pen_x),
        .pen_y       (pen_y),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .ext_x       (ext_x),
        .ext_y       (ext_y),
        .base_x      (base_x),
        .base_y      (base_y),
        .keep_x      (keep_x),
        .keep_y      (keep_y)
    );

    aabb_resolve #(
        .COORD_BITS(COORD_BITS)
    ) u_resolve (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .pen_x      (pen_x),
        .pen_y      (pen_y),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .ext_x      (ext_x),
        .ext_y      (ext_y),
        .base_x     (base_x),
        .base_y     (base_y),
        .keep_x     (keep_x),
        .keep_y     (keep_y),
        .done       (done),
        .hit_code   (hit_code),
        .moved_other(moved_other),
        .new_x      (new_x),
        .new_y      (new_y)
    );

endmodule
`default_nettype wire
